// ===== hdl/bsa_pkg.sv =====
// Shared types, constants and helper functions for the bitmap slot allocator.
// No dependencies; every other file in hdl/ except bsa_ram refers to this package by scope.
package bsa_pkg;

	localparam int WORD_BITS   = 32;
	localparam int MAX_SLOTS   = 1024;
	localparam int WORD_DEPTH  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WIDX_W      = $clog2(WORD_DEPTH);
	localparam int SLOT_W      = 10;
	localparam int ENT_W       = 11;
	localparam int FILL_W      = 9;
	localparam int FRAC_W      = 8;
	localparam int FILL_ONE    = 256;
	localparam int THR_W       = ENT_W + FRAC_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	// register reset values
	localparam logic [ENT_W-1:0]  ENTRY_TOTAL_RST = ENT_W'(1024);
	localparam logic [FILL_W-1:0] FILL_LIMIT_RST  = FILL_W'(256);

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_ENTRY_TOTAL   = 2'd0;
	localparam logic [1:0] REG_COUNTING_MODE = 2'd1;
	localparam logic [1:0] REG_FILL_LIMIT    = 2'd2;
	localparam logic [1:0] REG_START_POLICY  = 2'd3;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		op_t               operation;
		logic [SLOT_W-1:0] slot_index;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted_slot;
		logic              alloc_failed;
		logic              free_error;
	} result_t;

	// classified command held in the queue
	typedef struct packed {
		op_t               operation;
		logic [SLOT_W-1:0] slot_index;
		logic              oor;
	} cmd_t;

	// decoded configuration handed to the back end
	typedef struct packed {
		logic [ENT_W-1:0]  entries;
		logic [WIDX_W:0]   words;
		logic              counting;
		logic              start_policy;
		logic [THR_W-1:0]  threshold;
		logic              clear;
	} cfg_t;

	// Bits of word w that map to real slots.
	function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WIDX_W-1:0] w,
			input logic [ENT_W-1:0] entries);
		logic [ENT_W-BIT_W-1:0] hi;
		logic [BIT_W-1:0]       lo;
		logic [WORD_BITS-1:0]   m;
		hi = entries[ENT_W-1:BIT_W];
		lo = entries[BIT_W-1:0];
		if (hi > (ENT_W-BIT_W)'(w)) begin
			m = '1;
		end else if (hi == (ENT_W-BIT_W)'(w)) begin
			m = ~({WORD_BITS{1'b1}} << lo);
		end else begin
			m = '0;
		end
		return m;
	endfunction

	function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [WIDX_W-1:0] lowest_word(input logic [WORD_DEPTH-1:0] v);
		logic [WIDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) idx = WIDX_W'(i);
		end
		return idx;
	endfunction

endpackage

// ===== hdl/bsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/bsa_front.sv =====
// Front end: accepts request transactions, range-checks free requests.
// Depends on bsa_pkg; feeds bsa_queue.
module bsa_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bsa_pkg::in_item_t         cmd,
	input  logic [bsa_pkg::ENT_W-1:0] entries,
	output logic                      busy,
	input  logic                      q_full,
	output logic                      q_push,
	output bsa_pkg::cmd_t             q_data
);

	logic          valid_s1;
	bsa_pkg::cmd_t cmd_s1;
	logic          accept;

	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.operation  <= cmd.operation;
			cmd_s1.slot_index <= cmd.slot_index;
			cmd_s1.oor        <= ({1'b0, cmd.slot_index} >= entries);
		end
	end

endmodule

// ===== hdl/bsa_queue.sv =====
// Short FIFO of classified commands between front and back end.
// Depends on bsa_pkg.
module bsa_queue #(
	parameter int DEPTH = bsa_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bsa_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output bsa_pkg::cmd_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bsa_pkg::cmd_t    slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hdl/bsa_back.sv =====
// Back end: word search, bitmap read-modify-write, usage count, result register.
// Depends on bsa_pkg and bsa_ram.
module bsa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bsa_pkg::cfg_t     cfg,
	input  logic              q_empty,
	input  bsa_pkg::cmd_t     q_head,
	output logic              q_pop,
	output logic              done,
	output bsa_pkg::result_t  result
);

	localparam int WB = bsa_pkg::WORD_BITS;
	localparam int WD = bsa_pkg::WORD_DEPTH;
	localparam int WW = bsa_pkg::WIDX_W;
	localparam int BW = bsa_pkg::BIT_W;
	localparam int EW = bsa_pkg::ENT_W;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t          state_q;
	logic [WD-1:0]   full_q;    // word has no free valid bit
	logic [WD-1:0]   wvalid_q;  // word written since last clear
	logic [EW-1:0]   used_q;
	logic [WW-1:0]   start_q;
	logic            done_q;
	bsa_pkg::result_t result_q;

	// stage 1 (search/read) -> stage 2 (update)
	bsa_pkg::op_t    op_s1;
	logic [WW-1:0]   word_s1;
	logic [BW-1:0]   bit_s1;
	logic            alloc_ok_s1;
	logic            oor_s1;

	// search
	logic [WD-1:0]   has_free;
	logic [WD-1:0]   from_start;
	logic [WW-1:0]   pick;
	logic            limit_hit;
	logic            alloc_go;
	logic            is_alloc;
	logic [WW-1:0]   rd_word;
	logic [WW:0]     start_inc;
	logic [WW-1:0]   rr_next;

	// update
	logic [WB-1:0]   rdata;
	logic [WB-1:0]   word_data;
	logic [WB-1:0]   vmask;
	logic [WB-1:0]   free_bits;
	logic [BW-1:0]   abit;
	logic [WB-1:0]   a_onehot;
	logic [WB-1:0]   f_onehot;
	logic            free_ok;
	logic            in_exec;
	logic            we;
	logic [WB-1:0]   wdata;

	always_comb begin
		for (int w = 0; w < WD; w++) begin
			has_free[w] = !full_q[w] && ((WW+1)'(w) < cfg.words);
		end
	end

	assign from_start = has_free & ({WD{1'b1}} << start_q);
	assign pick       = (|from_start) ? bsa_pkg::lowest_word(from_start)
	                                  : bsa_pkg::lowest_word(has_free);
	assign limit_hit  = cfg.counting &&
	                    ({used_q, {bsa_pkg::FRAC_W{1'b0}}} >= cfg.threshold);
	assign alloc_go   = (cfg.entries != '0) && !limit_hit;
	assign is_alloc   = (q_head.operation == bsa_pkg::OP_ALLOC);
	assign rd_word    = is_alloc ? pick
	                             : q_head.slot_index[bsa_pkg::SLOT_W-1 -: WW];
	assign start_inc  = {1'b0, start_q} + (WW+1)'(1);
	assign rr_next    = (start_inc >= cfg.words) ? '0 : start_inc[WW-1:0];
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;

	bsa_ram #(
		.WIDTH (WB),
		.DEPTH (WD)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (word_s1),
		.wdata (wdata),
		.re    (q_pop),
		.raddr (rd_word),
		.rdata (rdata)
	);

	// unwritten words read as all clear
	assign in_exec   = (state_q == ST_EXEC);
	assign word_data = wvalid_q[word_s1] ? rdata : '0;
	assign vmask     = bsa_pkg::valid_mask(word_s1, cfg.entries);
	assign free_bits = ~word_data & vmask;
	assign abit      = bsa_pkg::lowest_bit(free_bits);
	assign a_onehot  = WB'(1) << abit;
	assign f_onehot  = WB'(1) << bit_s1;
	assign free_ok   = !oor_s1 && ((word_data & f_onehot) != '0);
	assign we        = in_exec && ((op_s1 == bsa_pkg::OP_ALLOC) ? alloc_ok_s1 : free_ok);
	assign wdata     = (op_s1 == bsa_pkg::OP_ALLOC) ? (word_data | a_onehot)
	                                                : (word_data & ~f_onehot);

	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			full_q   <= '0;
			wvalid_q <= '0;
			used_q   <= '0;
			start_q  <= '0;
			done_q   <= 1'b0;
		end else if (cfg.clear) begin
			state_q  <= ST_IDLE;
			full_q   <= '0;
			wvalid_q <= '0;
			used_q   <= '0;
			start_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
						// round robin advances on every allocate past the limit check when the entry total is nonzero
						if (is_alloc && alloc_go && !cfg.start_policy) start_q <= rr_next;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (we) begin
						wvalid_q[word_s1] <= 1'b1;
						full_q[word_s1]   <= &(wdata | ~vmask);
						if (cfg.start_policy) start_q <= word_s1;
						if (cfg.counting) begin
							if (op_s1 == bsa_pkg::OP_ALLOC) begin
								used_q <= used_q + EW'(1);
							end else if (used_q != '0) begin
								used_q <= used_q - EW'(1);
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1       <= q_head.operation;
			word_s1     <= rd_word;
			bit_s1      <= q_head.slot_index[BW-1:0];
			alloc_ok_s1 <= alloc_go && (|has_free);
			oor_s1      <= q_head.oor;
		end
		if (in_exec) begin
			if (op_s1 == bsa_pkg::OP_ALLOC) begin
				result_q.granted_slot <= alloc_ok_s1 ? bsa_pkg::SLOT_W'({word_s1, abit}) : '0;
				result_q.alloc_failed <= !alloc_ok_s1;
				result_q.free_error   <= 1'b0;
			end else begin
				result_q.granted_slot <= '0;
				result_q.alloc_failed <= 1'b0;
				result_q.free_error   <= !free_ok;
			end
		end
	end

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: APB register file and front/queue/back.
// Depends on bsa_pkg, bsa_front, bsa_queue, bsa_back (which holds bsa_ram).
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+------------------------------
//  request   | start / busy                    | cmd (operation, slot_index)
//  result    | done, one-cycle strobe          | result (granted_slot,
//            |                                 |   alloc_failed, free_error)
//  config    | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// Sequence: the back end takes each transaction through word search and bitmap
// read, then bit update and write-back, and pops no new transaction until the
// last one is through; a result strobes from the result register after the front
// stage, the queue, the registered bitmap read and the update when the queue is empty.
// Reset and every register write clear the bitmap (per-word valid bits, no
// clearing pass), the usage count and the start word.
// Stalls: busy rises only when the front stage and the queue are both full;
// results are never held off by the receiver.
module bitmap_slot_allocator #(
	parameter int QUEUE_DEPTH = bsa_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request transaction
	input  logic                          start,
	output logic                          busy,
	input  bsa_pkg::in_item_t             cmd,
	// result transaction
	output logic                          done,
	output bsa_pkg::result_t              result,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsa_pkg::PADDR_W-1:0]   paddr,
	input  logic [bsa_pkg::PDATA_W-1:0]   pwdata,
	output logic [bsa_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int EW = bsa_pkg::ENT_W;
	localparam int FW = bsa_pkg::FILL_W;
	localparam int TW = bsa_pkg::THR_W;

	// --- register file -----------------------------------------------------
	logic [EW-1:0] entry_total_q;
	logic          counting_mode_q;
	logic [FW-1:0] fill_limit_q;
	logic          start_policy_q;
	logic          cfg_wr;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total_q   <= bsa_pkg::ENTRY_TOTAL_RST;
			counting_mode_q <= 1'b0;
			fill_limit_q    <= bsa_pkg::FILL_LIMIT_RST;
			start_policy_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bsa_pkg::REG_ENTRY_TOTAL:   entry_total_q   <= pwdata[EW-1:0];
				bsa_pkg::REG_COUNTING_MODE: counting_mode_q <= pwdata[0];
				bsa_pkg::REG_FILL_LIMIT:    fill_limit_q    <= pwdata[FW-1:0];
				bsa_pkg::REG_START_POLICY:  start_policy_q  <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bsa_pkg::REG_ENTRY_TOTAL:   prdata = bsa_pkg::PDATA_W'(entry_total_q);
			bsa_pkg::REG_COUNTING_MODE: prdata = bsa_pkg::PDATA_W'(counting_mode_q);
			bsa_pkg::REG_FILL_LIMIT:    prdata = bsa_pkg::PDATA_W'(fill_limit_q);
			bsa_pkg::REG_START_POLICY:  prdata = bsa_pkg::PDATA_W'(start_policy_q);
		endcase
	end

	// --- derived configuration ----------------------------------------------
	// Entry totals above the slot count and fill limits above one whole act
	// as the maximum.
	logic [EW-1:0]    entries_c;
	logic [FW-1:0]    limit_c;
	logic [EW-1:0]    words_sum;
	logic [FW+EW-1:0] thr_prod;
	logic [TW-1:0]    threshold_q;
	bsa_pkg::cfg_t    cfg;

	assign entries_c = (entry_total_q > EW'(bsa_pkg::MAX_SLOTS)) ? EW'(bsa_pkg::MAX_SLOTS)
	                                                              : entry_total_q;
	assign limit_c   = (fill_limit_q > FW'(bsa_pkg::FILL_ONE)) ? FW'(bsa_pkg::FILL_ONE)
	                                                           : fill_limit_q;
	// entries_c is at most MAX_SLOTS, so the rounding add cannot carry out
	assign words_sum = entries_c + EW'(bsa_pkg::WORD_BITS - 1);
	// limit check is used_count*256 >= limit*entries, exact in integers
	assign thr_prod  = {{EW{1'b0}}, limit_c} * {{FW{1'b0}}, entries_c};

	// threshold only moves on a register write; the back end reads it once any
	// following request has passed the front stage and the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= TW'(bsa_pkg::FILL_ONE * bsa_pkg::MAX_SLOTS);
		end else begin
			threshold_q <= thr_prod[TW-1:0];
		end
	end

	always_comb begin
		cfg.entries      = entries_c;
		cfg.words        = words_sum[EW-1:bsa_pkg::BIT_W];
		cfg.counting     = counting_mode_q;
		cfg.start_policy = start_policy_q;
		cfg.threshold    = threshold_q;
		cfg.clear        = cfg_wr;
	end

	// --- datapath -------------------------------------------------------------
	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	bsa_pkg::cmd_t q_in;
	bsa_pkg::cmd_t q_head;

	bsa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.entries (entries_c),
		.busy    (busy),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	bsa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	bsa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== hdl/bsa_checker.sv =====
// Port-level checks on result transactions of the bitmap slot allocator.
// Depends on bsa_pkg; bound to bitmap_slot_allocator below.
module bsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             done,
	input bsa_pkg::result_t result
);

	// back end returns to idle between transactions, so results never strobe back to back
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes in consecutive cycles");

	a_fail_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.alloc_failed || result.free_error) |-> result.granted_slot == '0)
		else $error("slot number reported with a failed transaction");

	a_one_error: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.alloc_failed && result.free_error))
		else $error("allocate and free errors flagged together");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.done   (done),
	.result (result)
);
